/* hw/rtl/gzhs_pkg.sv */
`timescale 1ns / 1ps

package gzhs_pkg;

  // Width of the running byte offset; it saturates at all ones.
  localparam int unsigned OFFSET_BITS  = 24;
  localparam int unsigned DATA_START_W = 24;
  localparam int unsigned SKIP_W       = 16;
  localparam int unsigned FLAGS_W      = 5;

  localparam logic [OFFSET_BITS-1:0] POS_LIMIT = {OFFSET_BITS{1'b1}};

  localparam logic [7:0] GZ_ID1     = 8'h1F;
  localparam logic [7:0] GZ_DEFLATE = 8'd8;

  // Bit positions in the flags byte
  localparam int unsigned FL_HCRC    = 1;
  localparam int unsigned FL_EXTRA   = 2;
  localparam int unsigned FL_NAME    = 3;
  localparam int unsigned FL_COMMENT = 4;

  localparam logic [SKIP_W-1:0] MAGIC_SKIP_ID1 = SKIP_W'(1);
  localparam logic [SKIP_W-1:0] MAGIC_SKIP_PAD = SKIP_W'(2);
  localparam logic [SKIP_W-1:0] FIXED_SKIP     = SKIP_W'(6);
  localparam logic [SKIP_W-1:0] HCRC_SKIP      = SKIP_W'(2);
  localparam logic [SKIP_W-1:0] TRAIL_SKIP     = SKIP_W'(8);

  typedef enum logic [3:0] {
    PH_PAD     = 4'd0,
    PH_MAGIC   = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLO     = 4'd5,
    PH_XHI     = 4'd6,
    PH_XDATA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_TRAIL   = 4'd11,
    PH_PAYLOAD = 4'd12,
    PH_ERROR   = 4'd13
  } phase_t;

  // Header part that has just ended, used to pick the next present part
  typedef enum logic [2:0] {
    ST_FIXED   = 3'd0,
    ST_EXTRA   = 3'd1,
    ST_NAME    = 3'd2,
    ST_COMMENT = 3'd3,
    ST_HCRC    = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    STS_HEADER  = 2'd0,
    STS_LAST    = 2'd1,
    STS_ERROR   = 2'd2,
    STS_PAYLOAD = 2'd3
  } status_t;

  typedef struct packed {
    phase_t            phase;
    logic [SKIP_W-1:0] skip;
    logic              load_skip;
  } next_part_t;

  // First present optional part after the given stage, else the trailer
  function automatic next_part_t go_after(input stage_t st, input logic [FLAGS_W-1:0] fl);
    next_part_t r;
    r.phase     = PH_TRAIL;
    r.skip      = TRAIL_SKIP;
    r.load_skip = 1'b1;
    if (st < ST_EXTRA && fl[FL_EXTRA]) begin
      r.phase     = PH_XLO;
      r.load_skip = 1'b0;
    end else if (st < ST_NAME && fl[FL_NAME]) begin
      r.phase     = PH_NAME;
      r.load_skip = 1'b0;
    end else if (st < ST_COMMENT && fl[FL_COMMENT]) begin
      r.phase     = PH_COMMENT;
      r.load_skip = 1'b0;
    end else if (st < ST_HCRC && fl[FL_HCRC]) begin
      r.phase = PH_HCRC;
      r.skip  = HCRC_SKIP;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/gzip_header_skipper.sv */
`timescale 1ns / 1ps

// Channel | Dir | tdata                  | tuser       | tlast
// in_     | in  | [7:0] byte_value       | [0] restart | -
// out_    | out | [23:0] data_start      | [1:0] status| -
//
// One byte is taken per cycle; the result appears in the output register on
// the following cycle. The phase update is a single pass of short logic.
// in_tready is high whenever the output register is empty or being drained
// this cycle, so a stalled consumer holds the result and stalls the input.
// rst_n (synchronous, active low) returns the parser to the pad check phase
// with the byte offset at zero; a restart flag on a byte does the same.

module gzip_header_skipper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] data_start
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned OB = gzhs_pkg::OFFSET_BITS;
  localparam int unsigned SW = gzhs_pkg::SKIP_W;
  localparam int unsigned FW = gzhs_pkg::FLAGS_W;
  localparam int unsigned DW = gzhs_pkg::DATA_START_W;

  gzhs_pkg::phase_t  phase_r, phase_nxt;
  logic [OB-1:0]     pos_r, pos_nxt;
  logic [SW-1:0]     skip_r, skip_nxt;
  logic [FW-1:0]     flags_r, flags_nxt;
  logic [7:0]        xlo_r, xlo_nxt;

  logic              out_valid_r, out_valid_nxt;
  gzhs_pkg::status_t out_status_r, out_status_nxt;
  logic [DW-1:0]     out_start_r, out_start_nxt;

  logic accept;

  assign in_tready  = ~out_valid_r | out_tready;
  assign accept     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_start_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    gzhs_pkg::phase_t     ph_b;
    logic [OB-1:0]        pos_b;
    logic [SW-1:0]        skip_b;
    logic [FW-1:0]        flags_b;
    logic [7:0]           xlo_b;
    logic                 skip_done;
    logic [SW-1:0]        skip_dec;
    logic [SW-1:0]        xlen;
    gzhs_pkg::next_part_t np;

    // restart wipes the parse before this byte is looked at
    ph_b    = in_tuser ? gzhs_pkg::PH_PAD : phase_r;
    pos_b   = in_tuser ? '0 : pos_r;
    skip_b  = in_tuser ? '0 : skip_r;
    flags_b = in_tuser ? '0 : flags_r;
    xlo_b   = in_tuser ? '0 : xlo_r;

    skip_done = (skip_b <= SW'(1));
    skip_dec  = skip_done ? '0 : skip_b - SW'(1);
    xlen      = SW'({in_tdata, xlo_b});
    np        = gzhs_pkg::go_after(gzhs_pkg::ST_FIXED, flags_b);

    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    skip_nxt       = skip_r;
    flags_nxt      = flags_r;
    xlo_nxt        = xlo_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;

    if (accept) begin
      phase_nxt      = ph_b;
      pos_nxt        = (pos_b < gzhs_pkg::POS_LIMIT) ? pos_b + OB'(1) : pos_b;
      skip_nxt       = skip_b;
      flags_nxt      = flags_b;
      xlo_nxt        = xlo_b;
      out_valid_nxt  = 1'b1;
      out_status_nxt = gzhs_pkg::STS_HEADER;
      out_start_nxt  = '0;

      case (ph_b)
        gzhs_pkg::PH_PAD: begin
          skip_nxt  = (in_tdata == gzhs_pkg::GZ_ID1) ? gzhs_pkg::MAGIC_SKIP_ID1
                                                     : gzhs_pkg::MAGIC_SKIP_PAD;
          phase_nxt = gzhs_pkg::PH_MAGIC;
        end
        gzhs_pkg::PH_MAGIC: begin
          skip_nxt = skip_dec;
          if (skip_done) begin
            phase_nxt = gzhs_pkg::PH_METHOD;
          end
        end
        gzhs_pkg::PH_METHOD: begin
          if (in_tdata != gzhs_pkg::GZ_DEFLATE) begin
            phase_nxt      = gzhs_pkg::PH_ERROR;
            out_status_nxt = gzhs_pkg::STS_ERROR;
          end else begin
            phase_nxt = gzhs_pkg::PH_FLAGS;
          end
        end
        gzhs_pkg::PH_FLAGS: begin
          flags_nxt = in_tdata[FW-1:0];
          skip_nxt  = gzhs_pkg::FIXED_SKIP;
          phase_nxt = gzhs_pkg::PH_FIXED;
        end
        gzhs_pkg::PH_FIXED: begin
          skip_nxt = skip_dec;
          if (skip_done) begin
            phase_nxt = np.phase;
            if (np.load_skip) begin
              skip_nxt = np.skip;
            end
          end
        end
        gzhs_pkg::PH_XLO: begin
          xlo_nxt   = in_tdata;
          phase_nxt = gzhs_pkg::PH_XHI;
        end
        gzhs_pkg::PH_XHI: begin
          np       = gzhs_pkg::go_after(gzhs_pkg::ST_EXTRA, flags_b);
          skip_nxt = xlen;
          if (xlen == '0) begin
            phase_nxt = np.phase;
            if (np.load_skip) begin
              skip_nxt = np.skip;
            end
          end else begin
            phase_nxt = gzhs_pkg::PH_XDATA;
          end
        end
        gzhs_pkg::PH_XDATA: begin
          np       = gzhs_pkg::go_after(gzhs_pkg::ST_EXTRA, flags_b);
          skip_nxt = skip_dec;
          if (skip_done) begin
            phase_nxt = np.phase;
            if (np.load_skip) begin
              skip_nxt = np.skip;
            end
          end
        end
        gzhs_pkg::PH_NAME: begin
          np = gzhs_pkg::go_after(gzhs_pkg::ST_NAME, flags_b);
          if (in_tdata == 8'd0) begin
            phase_nxt = np.phase;
            if (np.load_skip) begin
              skip_nxt = np.skip;
            end
          end
        end
        gzhs_pkg::PH_COMMENT: begin
          np = gzhs_pkg::go_after(gzhs_pkg::ST_COMMENT, flags_b);
          if (in_tdata == 8'd0) begin
            phase_nxt = np.phase;
            if (np.load_skip) begin
              skip_nxt = np.skip;
            end
          end
        end
        gzhs_pkg::PH_HCRC: begin
          np       = gzhs_pkg::go_after(gzhs_pkg::ST_HCRC, flags_b);
          skip_nxt = skip_dec;
          if (skip_done) begin
            phase_nxt = np.phase;
            if (np.load_skip) begin
              skip_nxt = np.skip;
            end
          end
        end
        gzhs_pkg::PH_TRAIL: begin
          skip_nxt = skip_dec;
          if (skip_done) begin
            phase_nxt      = gzhs_pkg::PH_PAYLOAD;
            out_status_nxt = gzhs_pkg::STS_LAST;
            // offset of the next byte, i.e. the first payload byte
            out_start_nxt  = DW'(pos_nxt);
          end
        end
        gzhs_pkg::PH_PAYLOAD: begin
          out_status_nxt = gzhs_pkg::STS_PAYLOAD;
        end
        default: begin
          // bad method is sticky until the next restart
          phase_nxt      = gzhs_pkg::PH_ERROR;
          out_status_nxt = gzhs_pkg::STS_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= gzhs_pkg::PH_PAD;
      pos_r       <= '0;
      skip_r      <= '0;
      flags_r     <= '0;
      xlo_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      skip_r      <= skip_nxt;
      flags_r     <= flags_nxt;
      xlo_r       <= xlo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

endmodule
